@@ rtl/fwep_pkg.sv @@
// Shared types, constants and per-byte parse functions for the elevation text parser.
// No dependencies; used by every module of the block.
package fwep_pkg;

  localparam logic [7:0]  CH_LF       = 8'd10;
  localparam logic [7:0]  CH_CR       = 8'd13;
  localparam logic [7:0]  CH_SPACE    = 8'd32;
  localparam logic [7:0]  CH_MINUS    = 8'd45;
  localparam logic [7:0]  CH_ZERO     = 8'd48;
  localparam logic [7:0]  CH_NINE     = 8'd57;

  localparam logic [14:0] PREFIX_LEN   = 15'd10;
  localparam logic [14:0] LINE_CNT_MAX = 15'd32767;
  localparam logic [2:0]  FIELD_LEN    = 3'd5;

  localparam logic [12:0] MAX_COLUMNS  = 13'd4096;
  localparam logic [12:0] MAX_ROWS     = 13'd4096;

  localparam logic [16:0] SENTINEL_A   = 17'd1111;
  localparam logic [16:0] SENTINEL_B   = 17'd9999;

  localparam logic [1:0]  PH_SPACES    = 2'd0;
  localparam logic [1:0]  PH_DIGITS    = 2'd1;
  localparam logic [1:0]  PH_DONE      = 2'd2;

  localparam logic [1:0]  CFG_NUM_COLUMNS = 2'd0;
  localparam logic [1:0]  CFG_NUM_ROWS    = 2'd1;
  localparam logic [1:0]  CFG_NODATA      = 2'd2;

  localparam logic [12:0]        RST_NUM_COLUMNS = 13'd4096;
  localparam logic [12:0]        RST_NUM_ROWS    = 13'd4096;
  localparam logic signed [20:0] RST_NODATA      = -21'sd99990;

  typedef struct packed {
    logic [12:0]        lim_cols;
    logic [12:0]        lim_rows;
    logic signed [20:0] nodata;
  } cfg_t;

  typedef struct packed {
    logic [14:0] line_cnt;
    logic [12:0] row;
    logic [12:0] col;
    logic [2:0]  fidx;
    logic [16:0] acc;
    logic        minus;
    logic [1:0]  phase;
    logic        held_cr;
  } state_t;

  typedef struct packed {
    logic               v;
    logic [11:0]        row_index;
    logic [11:0]        column_index;
    logic signed [20:0] value_tenths;
    logic               is_nodata;
  } rec_t;

  typedef struct packed {
    state_t st;
    rec_t   rec;
  } step_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  typedef struct packed {
    rec_t rec;
    logic last;
  } ent_t;

  function automatic state_t clear_field(state_t s);
    state_t r;
    r       = s;
    r.fidx  = 3'd0;
    r.acc   = 17'd0;
    r.minus = 1'b0;
    r.phase = PH_SPACES;
    return r;
  endfunction

  function automatic step_t close_field(state_t s, cfg_t cfg);
    step_t              r;
    logic signed [20:0] mag;
    logic               nod;
    mag = signed'({4'd0, s.acc});
    nod = s.minus && ((s.acc == SENTINEL_A) || (s.acc == SENTINEL_B));
    r.rec.v            = (s.row < cfg.lim_rows) && (s.col < cfg.lim_cols);
    r.rec.row_index    = s.row[11:0];
    r.rec.column_index = s.col[11:0];
    r.rec.value_tenths = nod ? cfg.nodata : (s.minus ? -mag : mag);
    r.rec.is_nodata    = nod;
    r.st = s;
    if (s.col < cfg.lim_cols) begin
      r.st.col = s.col + 13'd1;
    end
    r.st = clear_field(r.st);
    return r;
  endfunction

  function automatic step_t take_char(state_t s, logic [7:0] ch, cfg_t cfg);
    step_t r;
    logic  is_dig;
    is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    r.st  = s;
    r.rec = '0;
    if (s.line_cnt < PREFIX_LEN) begin
      r.st.line_cnt = s.line_cnt + 15'd1;
    end else begin
      if (s.line_cnt < LINE_CNT_MAX) begin
        r.st.line_cnt = s.line_cnt + 15'd1;
      end
      if (s.fidx == 3'd0) begin
        r.st = clear_field(r.st);
      end
      case (r.st.phase)
        PH_SPACES: begin
          if (ch == CH_MINUS) begin
            r.st.minus = 1'b1;
            r.st.phase = PH_DIGITS;
          end else if (is_dig) begin
            r.st.acc   = {13'd0, ch[3:0]};
            r.st.phase = PH_DIGITS;
          end else if (ch != CH_SPACE) begin
            r.st.phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            r.st.acc = 17'((r.st.acc << 3) + (r.st.acc << 1) + {13'd0, ch[3:0]});
          end else begin
            r.st.phase = PH_DONE;
          end
        end
        default: ;
      endcase
      r.st.fidx = s.fidx + 3'd1;
      if (r.st.fidx >= FIELD_LEN) begin
        r = close_field(r.st, cfg);
      end
    end
    return r;
  endfunction

  function automatic step_t end_line(state_t s, cfg_t cfg);
    step_t r;
    r.st  = s;
    r.rec = '0;
    if (s.fidx != 3'd0) begin
      r = close_field(s, cfg);
    end
    r.st.line_cnt = 15'd0;
    r.st.col      = 13'd0;
    r.st = clear_field(r.st);
    if (r.st.row < cfg.lim_rows) begin
      r.st.row = r.st.row + 13'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/fwep_cfg.sv @@
// Configuration registers for the elevation text parser; clamps the limits.
// Depends on fwep_pkg.
module fwep_cfg import fwep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  output cfg_t        cfg_o
);

  logic [12:0]        num_cols_q, num_cols_d;
  logic [12:0]        num_rows_q, num_rows_d;
  logic signed [20:0] nodata_q, nodata_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    num_cols_d = num_cols_q;
    num_rows_d = num_rows_q;
    nodata_d   = nodata_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_COLUMNS: num_cols_d = cfg_data_i[12:0];
        CFG_NUM_ROWS:    num_rows_d = cfg_data_i[12:0];
        CFG_NODATA:      nodata_d   = signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= RST_NUM_COLUMNS;
      num_rows_q <= RST_NUM_ROWS;
      nodata_q   <= RST_NODATA;
    end else begin
      num_cols_q <= num_cols_d;
      num_rows_q <= num_rows_d;
      nodata_q   <= nodata_d;
    end
  end

  assign cfg_o.lim_cols = (num_cols_q > MAX_COLUMNS) ? MAX_COLUMNS : num_cols_q;
  assign cfg_o.lim_rows = (num_rows_q > MAX_ROWS) ? MAX_ROWS : num_rows_q;
  assign cfg_o.nodata   = nodata_q;

endmodule

@@ rtl/fwep_core.sv @@
// Parse state and single-pass byte update: held CR, byte, line close, compaction.
// Depends on fwep_pkg.
module fwep_core import fwep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       take_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_data_i,
  output push_t      push_o
);

  state_t state_q, state_d;
  step_t  ra, rb, rc;
  logic   is_lf, is_cr;

  assign is_lf = (text_byte_i == CH_LF);
  assign is_cr = (text_byte_i == CH_CR);

  always_comb begin
    ra.st  = state_q;
    ra.rec = '0;
    if (!is_lf && state_q.held_cr) begin
      ra = take_char(state_q, CH_CR, cfg_i);
    end
    rb.st  = ra.st;
    rb.rec = '0;
    if (!is_lf && !is_cr) begin
      rb = take_char(ra.st, text_byte_i, cfg_i);
    end
    rc.st  = rb.st;
    rc.rec = '0;
    if (is_lf || end_of_data_i) begin
      rc = end_line(rb.st, cfg_i);
    end
    state_d         = rc.st;
    state_d.held_cr = is_cr && !end_of_data_i;
    if (end_of_data_i) begin
      state_d = '0;
    end
  end

  always_comb begin
    push_o.n  = 2'(ra.rec.v) + 2'(rb.rec.v) + 2'(rc.rec.v);
    if (push_o.n == 2'd3) begin
      push_o.n = 2'd2;
    end
    push_o.r0 = ra.rec.v ? ra.rec : (rb.rec.v ? rb.rec : rc.rec);
    push_o.r1 = (ra.rec.v && rb.rec.v) ? rb.rec : rc.rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (take_i) begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/fwep_outbuf.sv @@
// Two-entry result register between the parse core and the output stream.
// Depends on fwep_pkg.
module fwep_outbuf import fwep_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  push_t push_data_i,
  output logic  push_ready_o,
  output logic  valid_o,
  input  logic  ready_i,
  output ent_t  head_o
);

  logic [1:0] cnt_q, cnt_d;
  ent_t       ent0_q, ent0_d;
  ent_t       ent1_q, ent1_d;
  logic       pop;

  assign pop          = valid_o && ready_i;
  assign valid_o      = (cnt_q != 2'd0);
  assign push_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);
  assign head_o       = ent0_q;

  always_comb begin
    cnt_d  = cnt_q;
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    if (push_i) begin
      cnt_d       = push_data_i.n;
      ent0_d.rec  = push_data_i.r0;
      ent0_d.last = (push_data_i.n == 2'd1);
      ent1_d.rec  = push_data_i.r1;
      ent1_d.last = 1'b1;
    end else if (pop) begin
      cnt_d  = cnt_q - 2'd1;
      ent0_d = ent1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule

@@ rtl/fixed_width_elevation_text_parser.sv @@
// Top level of the fixed-width elevation text parser.
// Depends on fwep_pkg, fwep_cfg, fwep_core and fwep_outbuf.
//
//   port group  dir  width           word
//   s_axis      in   8 + tlast       one text byte, tlast = end of data
//   m_axis      out  48 + tuser/last row, column, value in tenths; tuser = nodata
//   cfg         in   2 + 21          register index and write data
//
// One byte is taken per cycle while s_axis_tready is high; its results land in
// the output register the next cycle. A byte that closes two fields gives two words.
// s_axis_tready stays high while the output register is empty or drains this cycle.
// Reset clears the parse state and loads the register defaults; no clearing pass.
module fixed_width_elevation_text_parser import fwep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [11:0] row_index, [23:12] column_index,
                                      // [44:24] value_tenths, [47:45] zero
  output logic        m_axis_tuser,   // [0] is_nodata
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);

  cfg_t  cfg;
  push_t push;
  ent_t  head;
  logic  take;

  assign take = s_axis_tvalid && s_axis_tready;

  fwep_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fwep_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .take_i        (take),
    .text_byte_i   (s_axis_tdata),
    .end_of_data_i (s_axis_tlast),
    .push_o        (push)
  );

  fwep_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (take),
    .push_data_i  (push),
    .push_ready_o (s_axis_tready),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .head_o       (head)
  );

  assign m_axis_tdata = {3'b000, head.rec.value_tenths, head.rec.column_index,
                         head.rec.row_index};
  assign m_axis_tuser = head.rec.is_nodata;
  assign m_axis_tlast = head.last;

endmodule
